/* rtl/sfcf_pkg.sv */
package sfcf_pkg;

    localparam int CAPACITY_BYTES = 4194304;
    localparam int PAGE_BYTES     = 256;
    localparam int SECTOR_BYTES   = 4096;
    localparam int BLOCK_BYTES    = 65536;

    localparam int ADDR_W      = 24;
    localparam int LEN_W       = 23;
    localparam int SADDR_W     = 22;
    localparam int UNIT_W      = 10;
    localparam int PAGE_LOG2   = $clog2(PAGE_BYTES);
    localparam int SECTOR_LOG2 = $clog2(SECTOR_BYTES);
    localparam int BLOCK_LOG2  = $clog2(BLOCK_BYTES);
    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] CMD_ID     = 4'd0;
    localparam logic [3:0] CMD_WREN   = 4'd1;
    localparam logic [3:0] CMD_WRDIS  = 4'd2;
    localparam logic [3:0] CMD_STATUS = 4'd3;
    localparam logic [3:0] CMD_READ   = 4'd4;
    localparam logic [3:0] CMD_PROG   = 4'd5;
    localparam logic [3:0] CMD_SERASE = 4'd6;
    localparam logic [3:0] CMD_BERASE = 4'd7;
    localparam logic [3:0] CMD_CERASE = 4'd8;
    localparam logic [3:0] CMD_DATA   = 4'd9;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_RANGE   = 3'd1;
    localparam logic [2:0] ST_LENGTH  = 3'd2;
    localparam logic [2:0] ST_BUSY    = 3'd3;
    localparam logic [2:0] ST_NO_XFER = 3'd4;
    localparam logic [2:0] ST_OPEN    = 3'd5;

    localparam logic [7:0] OP_WREN   = 8'h06;
    localparam logic [7:0] OP_WRDIS  = 8'h04;
    localparam logic [7:0] OP_RDSR   = 8'h05;
    localparam logic [7:0] OP_READ   = 8'h03;
    localparam logic [7:0] OP_PROG   = 8'h02;
    localparam logic [7:0] OP_SERASE = 8'h20;
    localparam logic [7:0] OP_BERASE = 8'hD8;
    localparam logic [7:0] OP_CERASE = 8'h60;
    localparam logic [7:0] OP_RDID   = 8'h9F;
    localparam logic [7:0] OP_DUMMY  = 8'h00;

    typedef enum logic [3:0] {
        K_REFUSE,
        K_RD_DATA,
        K_PG_DATA,
        K_ID,
        K_WREN,
        K_WRDIS,
        K_STATUS,
        K_READ,
        K_PROG,
        K_SERASE,
        K_BERASE,
        K_CERASE
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [2:0]        status;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        dval;
        logic              flag;
    } job_t;

endpackage

/* rtl/sfcf_front.sv */
module sfcf_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  logic [3:0]              command,
    input  logic [sfcf_pkg::SADDR_W-1:0] address,
    input  logic [sfcf_pkg::LEN_W-1:0]   length,
    input  logic [sfcf_pkg::UNIT_W-1:0]  erase_unit,
    input  logic [7:0]              data_value,
    input  logic                    device_busy,
    output sfcf_pkg::job_t          job
);
    import sfcf_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_READ,
        MODE_PROG
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic [LEN_W-1:0]  left_reg, left_next;

    logic [ADDR_W-1:0] addr_x;
    logic [ADDR_W-1:0] len_x;
    logic [ADDR_W-1:0] unit_x;
    logic [ADDR_W-1:0] rd_end;
    logic [ADDR_W-1:0] pg_end;
    logic              rd_bad;
    logic              pg_range_bad;
    logic              pg_len_bad;

    assign addr_x = ADDR_W'(address);
    assign len_x  = ADDR_W'(length);
    assign unit_x = ADDR_W'(erase_unit);
    assign rd_end = addr_x + len_x;
    assign pg_end = ADDR_W'(address[PAGE_LOG2-1:0]) + len_x;

    assign rd_bad       = (addr_x > ADDR_W'(CAPACITY_BYTES)) ||
                          (rd_end > ADDR_W'(CAPACITY_BYTES));
    assign pg_range_bad = addr_x > ADDR_W'(CAPACITY_BYTES - PAGE_BYTES);
    assign pg_len_bad   = (len_x == '0) || (len_x > ADDR_W'(PAGE_BYTES)) ||
                          (pg_end > ADDR_W'(PAGE_BYTES));

    always_comb begin
        job        = '0;
        job.kind   = K_REFUSE;
        job.status = ST_NO_XFER;
        job.addr   = addr_x;
        job.dval   = data_value;
        job.flag   = 1'b0;
        mode_next  = mode_reg;
        left_next  = left_reg;
        if (command == CMD_DATA) begin
            if (mode_reg != MODE_IDLE) begin
                job.kind   = (mode_reg == MODE_READ) ? K_RD_DATA : K_PG_DATA;
                job.status = ST_OK;
                job.flag   = (left_reg <= LEN_W'(1));
                if (left_reg <= LEN_W'(1)) begin
                    mode_next = MODE_IDLE;
                    left_next = '0;
                end else begin
                    left_next = left_reg - LEN_W'(1);
                end
            end
        end else if (command > CMD_DATA) begin
            job.status = ST_NO_XFER;
        end else if (mode_reg != MODE_IDLE) begin
            job.status = ST_OPEN;
        end else begin
            job.status = ST_OK;
            unique case (command)
                CMD_ID: begin
                    job.kind = K_ID;
                end
                CMD_WREN: begin
                    job.kind = K_WREN;
                end
                CMD_WRDIS: begin
                    job.kind = K_WRDIS;
                end
                CMD_STATUS: begin
                    job.kind = K_STATUS;
                end
                CMD_READ: begin
                    if (rd_bad) begin
                        job.status = ST_RANGE;
                    end else if (device_busy) begin
                        job.status = ST_BUSY;
                    end else begin
                        job.kind = K_READ;
                        job.flag = (length == '0);
                        if (length != '0) begin
                            mode_next = MODE_READ;
                            left_next = length;
                        end
                    end
                end
                CMD_PROG: begin
                    if (pg_range_bad) begin
                        job.status = ST_RANGE;
                    end else if (pg_len_bad) begin
                        job.status = ST_LENGTH;
                    end else if (device_busy) begin
                        job.status = ST_BUSY;
                    end else begin
                        job.kind  = K_PROG;
                        mode_next = MODE_PROG;
                        left_next = length;
                    end
                end
                CMD_SERASE: begin
                    if (unit_x > ADDR_W'(CAPACITY_BYTES / SECTOR_BYTES - 1)) begin
                        job.status = ST_RANGE;
                    end else begin
                        job.kind = K_SERASE;
                        job.addr = unit_x << SECTOR_LOG2;
                    end
                end
                CMD_BERASE: begin
                    if (unit_x > ADDR_W'(CAPACITY_BYTES / BLOCK_BYTES - 1)) begin
                        job.status = ST_RANGE;
                    end else begin
                        job.kind = K_BERASE;
                        job.addr = unit_x << BLOCK_LOG2;
                    end
                end
                CMD_CERASE: begin
                    if (device_busy) begin
                        job.status = ST_BUSY;
                    end else begin
                        job.kind = K_CERASE;
                    end
                end
                default: begin
                    job.status = ST_NO_XFER;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            left_reg <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            left_reg <= left_next;
        end
    end

endmodule

/* rtl/sfcf_queue.sv */
module sfcf_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sfcf_pkg::job_t push_job,
    input  logic           pop,
    output sfcf_pkg::job_t head_job,
    output logic           head_valid,
    output logic           full
);
    import sfcf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign head_job   = mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (PTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/sfcf_back.sv */
module sfcf_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  sfcf_pkg::job_t head_job,
    input  logic           head_valid,
    output logic           pop,
    input  logic           m_tready,
    output logic           m_tvalid,
    output logic           m_tlast,
    output logic [7:0]     spi_byte,
    output logic           byte_valid,
    output logic           deselect_after,
    output logic [7:0]     read_byte,
    output logic           read_valid,
    output logic [2:0]     status
);
    import sfcf_pkg::*;

    job_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] idx_reg, idx_next;

    logic       m_valid_reg, m_valid_next;
    logic       m_last_reg;
    logic [7:0] m_byte_reg;
    logic       m_bvalid_reg;
    logic       m_desel_reg;
    logic [7:0] m_rbyte_reg;
    logic       m_rvalid_reg;
    logic [2:0] m_status_reg;

    logic       out_free;
    logic       emit;
    logic [2:0] last_idx;
    logic       is_last;
    logic [7:0] e_byte;
    logic       e_bvalid;
    logic       e_desel;
    logic [7:0] e_rbyte;
    logic       e_rvalid;
    logic [7:0] a2, a1, a0;

    assign a2 = cur_reg.addr[23:16];
    assign a1 = cur_reg.addr[15:8];
    assign a0 = cur_reg.addr[7:0];

    always_comb begin
        last_idx = 3'd0;
        e_byte   = 8'h00;
        e_bvalid = 1'b1;
        e_desel  = 1'b0;
        e_rbyte  = 8'h00;
        e_rvalid = 1'b0;
        unique case (cur_reg.kind)
            K_REFUSE: begin
                e_bvalid = 1'b0;
            end
            K_RD_DATA: begin
                e_desel  = cur_reg.flag;
                e_rbyte  = cur_reg.dval;
                e_rvalid = 1'b1;
            end
            K_PG_DATA: begin
                e_byte  = cur_reg.dval;
                e_desel = cur_reg.flag;
            end
            K_ID: begin
                last_idx = 3'd3;
                e_byte   = (idx_reg == 3'd0) ? OP_RDID : OP_DUMMY;
                e_desel  = (idx_reg == 3'd3);
            end
            K_WREN: begin
                e_byte  = OP_WREN;
                e_desel = 1'b1;
            end
            K_WRDIS: begin
                e_byte  = OP_WRDIS;
                e_desel = 1'b1;
            end
            K_STATUS: begin
                last_idx = 3'd1;
                e_byte   = (idx_reg == 3'd0) ? OP_RDSR : OP_DUMMY;
                e_desel  = (idx_reg == 3'd1);
            end
            K_READ: begin
                last_idx = 3'd3;
                case (idx_reg)
                    3'd0:    e_byte = OP_READ;
                    3'd1:    e_byte = a2;
                    3'd2:    e_byte = a1;
                    default: e_byte = a0;
                endcase
                e_desel = (idx_reg == 3'd3) && cur_reg.flag;
            end
            K_PROG, K_SERASE, K_BERASE: begin
                last_idx = 3'd4;
                case (idx_reg)
                    3'd0: e_byte = OP_WREN;
                    3'd1: begin
                        if (cur_reg.kind == K_PROG) begin
                            e_byte = OP_PROG;
                        end else if (cur_reg.kind == K_SERASE) begin
                            e_byte = OP_SERASE;
                        end else begin
                            e_byte = OP_BERASE;
                        end
                    end
                    3'd2:    e_byte = a2;
                    3'd3:    e_byte = a1;
                    default: e_byte = a0;
                endcase
                e_desel = (idx_reg == 3'd0) ||
                          ((idx_reg == 3'd4) && (cur_reg.kind != K_PROG));
            end
            K_CERASE: begin
                last_idx = 3'd1;
                e_byte   = (idx_reg == 3'd0) ? OP_WREN : OP_CERASE;
                e_desel  = 1'b1;
            end
            default: begin
                e_bvalid = 1'b0;
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = cur_valid_reg && out_free;
    assign is_last  = (idx_reg == last_idx);
    assign pop      = head_valid && (!cur_valid_reg || (emit && is_last));

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop) begin
            cur_next       = head_job;
            cur_valid_next = 1'b1;
            idx_next       = 3'd0;
        end else if (emit) begin
            if (is_last) begin
                cur_valid_next = 1'b0;
                idx_next       = 3'd0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (emit) begin
            m_last_reg   <= is_last;
            m_byte_reg   <= e_byte;
            m_bvalid_reg <= e_bvalid;
            m_desel_reg  <= e_desel;
            m_rbyte_reg  <= e_rbyte;
            m_rvalid_reg <= e_rvalid;
            m_status_reg <= cur_reg.status;
        end
    end

    assign m_tvalid       = m_valid_reg;
    assign m_tlast        = m_last_reg;
    assign spi_byte       = m_byte_reg;
    assign byte_valid     = m_bvalid_reg;
    assign deselect_after = m_desel_reg;
    assign read_byte      = m_rbyte_reg;
    assign read_valid     = m_rvalid_reg;
    assign status         = m_status_reg;

endmodule

/* rtl/spi_flash_command_framer.sv */
// channel   direction  tdata (low bit up)                           tuser (low bit up)
// s_        in         address 22, length 23, erase_unit 10,        command 4, device_busy 1
//                      data_value 8, pad 1
// m_        out        spi_byte 8, deselect_after 1, read_byte 8,   byte_valid 1, read_valid 1,
//                      pad 7; tlast = last                          status 3
//
// one result leaves per cycle while m_tready is high; data items, refusals, write enable
// and write disable give one result, the others two to five, sent in turn by the back sequencer
// the front takes a request every cycle while the four-entry job queue has room
// a taken request passes the job queue and the current job register before m_tvalid rises
// reset clears the queue, the open transfer and the output register
// m_tready low holds the output register, then fills the queue, then drops s_tready
module spi_flash_command_framer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // address, length, erase_unit, data_value, pad
    input  logic [4:0]  s_tuser,   // command, device_busy
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // spi_byte, deselect_after, read_byte, pad
    output logic [4:0]  m_tuser,   // byte_valid, read_valid, status
    output logic        m_tlast
);
    import sfcf_pkg::*;

    logic       accept;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    job_t       new_job;
    job_t       head_job;
    logic [7:0] spi_byte;
    logic       byte_valid;
    logic       deselect_after;
    logic [7:0] read_byte;
    logic       read_valid;
    logic [2:0] status;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    sfcf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .command     (s_tuser[3:0]),
        .address     (s_tdata[21:0]),
        .length      (s_tdata[44:22]),
        .erase_unit  (s_tdata[54:45]),
        .data_value  (s_tdata[62:55]),
        .device_busy (s_tuser[4]),
        .job         (new_job)
    );

    sfcf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_job   (new_job),
        .pop        (q_pop),
        .head_job   (head_job),
        .head_valid (q_valid),
        .full       (q_full)
    );

    sfcf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_job       (head_job),
        .head_valid     (q_valid),
        .pop            (q_pop),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_tlast        (m_tlast),
        .spi_byte       (spi_byte),
        .byte_valid     (byte_valid),
        .deselect_after (deselect_after),
        .read_byte      (read_byte),
        .read_valid     (read_valid),
        .status         (status)
    );

    assign m_tdata = {7'b0, read_byte, deselect_after, spi_byte};
    assign m_tuser = {status, read_valid, byte_valid};

    a_refuse_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (status != ST_OK)) |-> (m_tlast && !byte_valid && !deselect_after))
        else $error("refusal not a lone result");

    a_read_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && read_valid) |-> (byte_valid && (spi_byte == OP_DUMMY) && m_tlast))
        else $error("read data result malformed");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("job queue popped while empty");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_full && !q_pop) |=> q_full)
        else $error("job queue lost an entry");

endmodule

/* bench/tb_spi_flash_command_framer.sv */
`timescale 1ns / 1ps

module tb_spi_flash_command_framer;
    import sfcf_pkg::*;

    localparam logic [3:0] CMD_UNKNOWN_MIN = 4'd10;
    localparam logic [3:0] CMD_UNKNOWN_MAX = 4'd15;
    localparam int RANDOM_PER_PHASE = 128;

    typedef enum logic [1:0] {XFER_IDLE, XFER_READ, XFER_PROG} xfer_t;
    typedef enum logic [1:0] {CHK_PREDICT, CHK_REFUSE, CHK_ONE_BYTE} chk_t;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       byte_valid;
        logic       deselect;
        logic [7:0] read_byte;
        logic       read_valid;
        logic [2:0] status;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [21:0] addr;
        logic [22:0] len;
        logic [9:0]  unit;
        logic [7:0]  dval;
        logic        busy;
        chk_t        chk;
        logic [7:0]  value;
        logic [2:0]  status;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [4:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    xfer_t       xfer_mode = XFER_IDLE;
    int unsigned xfer_left = 0;
    beat_t       beats_due[$];
    beat_t       framed[$];
    int          mismatches = 0;
    int          snd_idle = 0;
    int          rcv_idle = 0;

    spi_flash_command_framer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic beat_t refusal(input logic [2:0] st);
        beat_t b;
        b = '0;
        b.status = st;
        return b;
    endfunction

    function automatic beat_t spi_out(input logic [7:0] v, input logic desel);
        beat_t b;
        b = '0;
        b.spi_byte   = v;
        b.byte_valid = 1'b1;
        b.deselect   = desel;
        return b;
    endfunction

    function automatic void send_address(input int unsigned a, input logic desel);
        framed.push_back(spi_out(a[23:16], 1'b0));
        framed.push_back(spi_out(a[15:8], 1'b0));
        framed.push_back(spi_out(a[7:0], desel));
    endfunction

    // spi bytes and refusals that one request produces, state updated as it goes
    function automatic void frame_request(input row_t r);
        beat_t       b;
        int unsigned a;
        int unsigned l;
        int unsigned u;
        a = 32'(r.addr);
        l = 32'(r.len);
        u = 32'(r.unit);
        framed.delete();
        if (r.cmd == CMD_DATA) begin
            if (xfer_mode == XFER_IDLE) begin
                framed.push_back(refusal(ST_NO_XFER));
            end else begin
                b = '0;
                b.byte_valid = 1'b1;
                b.deselect   = (xfer_left <= 1);
                if (xfer_mode == XFER_READ) begin
                    b.read_byte  = r.dval;
                    b.read_valid = 1'b1;
                end else begin
                    b.spi_byte = r.dval;
                end
                framed.push_back(b);
                if (xfer_left <= 1) begin
                    xfer_mode = XFER_IDLE;
                    xfer_left = 0;
                end else begin
                    xfer_left--;
                end
            end
        end else if (r.cmd > CMD_DATA) begin
            framed.push_back(refusal(ST_NO_XFER));
        end else if (xfer_mode != XFER_IDLE) begin
            framed.push_back(refusal(ST_OPEN));
        end else begin
            case (r.cmd)
                CMD_ID: begin
                    framed.push_back(spi_out(OP_RDID, 1'b0));
                    framed.push_back(spi_out(OP_DUMMY, 1'b0));
                    framed.push_back(spi_out(OP_DUMMY, 1'b0));
                    framed.push_back(spi_out(OP_DUMMY, 1'b1));
                end
                CMD_WREN:  framed.push_back(spi_out(OP_WREN, 1'b1));
                CMD_WRDIS: framed.push_back(spi_out(OP_WRDIS, 1'b1));
                CMD_STATUS: begin
                    framed.push_back(spi_out(OP_RDSR, 1'b0));
                    framed.push_back(spi_out(OP_DUMMY, 1'b1));
                end
                CMD_READ: begin
                    if (a > CAPACITY_BYTES || l > CAPACITY_BYTES - a) begin
                        framed.push_back(refusal(ST_RANGE));
                    end else if (r.busy) begin
                        framed.push_back(refusal(ST_BUSY));
                    end else begin
                        framed.push_back(spi_out(OP_READ, 1'b0));
                        send_address(a, l == 0);
                        if (l != 0) begin
                            xfer_mode = XFER_READ;
                            xfer_left = l;
                        end
                    end
                end
                CMD_PROG: begin
                    if (a > CAPACITY_BYTES - PAGE_BYTES) begin
                        framed.push_back(refusal(ST_RANGE));
                    end else if (l < 1 || l > PAGE_BYTES ||
                                 (a % PAGE_BYTES) + l > PAGE_BYTES) begin
                        framed.push_back(refusal(ST_LENGTH));
                    end else if (r.busy) begin
                        framed.push_back(refusal(ST_BUSY));
                    end else begin
                        framed.push_back(spi_out(OP_WREN, 1'b1));
                        framed.push_back(spi_out(OP_PROG, 1'b0));
                        send_address(a, 1'b0);
                        xfer_mode = XFER_PROG;
                        xfer_left = l;
                    end
                end
                CMD_SERASE: begin
                    if (u > CAPACITY_BYTES / SECTOR_BYTES - 1) begin
                        framed.push_back(refusal(ST_RANGE));
                    end else begin
                        framed.push_back(spi_out(OP_WREN, 1'b1));
                        framed.push_back(spi_out(OP_SERASE, 1'b0));
                        send_address(u * SECTOR_BYTES, 1'b1);
                    end
                end
                CMD_BERASE: begin
                    if (u > CAPACITY_BYTES / BLOCK_BYTES - 1) begin
                        framed.push_back(refusal(ST_RANGE));
                    end else begin
                        framed.push_back(spi_out(OP_WREN, 1'b1));
                        framed.push_back(spi_out(OP_BERASE, 1'b0));
                        send_address(u * BLOCK_BYTES, 1'b1);
                    end
                end
                default: begin
                    if (r.busy) begin
                        framed.push_back(refusal(ST_BUSY));
                    end else begin
                        framed.push_back(spi_out(OP_WREN, 1'b1));
                        framed.push_back(spi_out(OP_CERASE, 1'b1));
                    end
                end
            endcase
        end
        b = framed.pop_back();
        b.last = 1'b1;
        framed.push_back(b);
    endfunction

    function automatic row_t req_row(input logic [3:0] cmd, input logic [21:0] addr,
                                     input logic [22:0] len, input logic [9:0] unit,
                                     input logic [7:0] dval, input logic busy,
                                     input chk_t chk, input logic [7:0] value,
                                     input logic [2:0] st);
        row_t r;
        r.cmd    = cmd;
        r.addr   = addr;
        r.len    = len;
        r.unit   = unit;
        r.dval   = dval;
        r.busy   = busy;
        r.chk    = chk;
        r.value  = value;
        r.status = st;
        return r;
    endfunction

    // mostly well-formed requests, data while a transfer is open, some noise
    function automatic row_t random_request();
        row_t        r;
        int unsigned pick;
        int unsigned offset;
        int unsigned span;
        r.cmd    = CMD_DATA;
        r.addr   = 22'($urandom);
        r.len    = 23'($urandom);
        r.unit   = 10'($urandom);
        r.dval   = 8'($urandom);
        r.busy   = ($urandom_range(99) < 10);
        r.chk    = CHK_PREDICT;
        r.value  = '0;
        r.status = '0;
        pick = $urandom_range(99);
        if (xfer_mode != XFER_IDLE) begin
            if (pick < 88) r.cmd = CMD_DATA;
            else if (pick < 94) r.cmd = 4'($urandom_range(CMD_CERASE, CMD_ID));
            else r.cmd = 4'($urandom_range(CMD_UNKNOWN_MAX, CMD_UNKNOWN_MIN));
            return r;
        end
        if (pick < 8) r.cmd = CMD_ID;
        else if (pick < 14) r.cmd = CMD_WREN;
        else if (pick < 20) r.cmd = CMD_WRDIS;
        else if (pick < 27) r.cmd = CMD_STATUS;
        else if (pick < 47) r.cmd = CMD_READ;
        else if (pick < 70) r.cmd = CMD_PROG;
        else if (pick < 78) r.cmd = CMD_SERASE;
        else if (pick < 85) r.cmd = CMD_BERASE;
        else if (pick < 90) r.cmd = CMD_CERASE;
        else if (pick < 94) r.cmd = CMD_DATA;
        else r.cmd = 4'($urandom_range(CMD_UNKNOWN_MAX, CMD_UNKNOWN_MIN));

        if (r.cmd == CMD_READ && $urandom_range(99) < 80) begin
            r.len = 23'($urandom_range(12, 0));
            if (r.addr > CAPACITY_BYTES - r.len) r.addr = 22'(CAPACITY_BYTES - r.len);
        end
        if (r.cmd == CMD_PROG) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                offset = $urandom_range(PAGE_BYTES - 1, 0);
                span   = PAGE_BYTES - offset;
                if ($urandom_range(99) < 3) r.len = 23'(span);
                else r.len = 23'($urandom_range(span > 16 ? 16 : span, 1));
                r.addr = 22'($urandom_range(CAPACITY_BYTES / PAGE_BYTES - 1, 0) * PAGE_BYTES
                              + offset);
            end else if (pick < 90) begin
                r.len = 23'($urandom_range(PAGE_BYTES + 2, 0));
            end
        end
        if (r.cmd == CMD_BERASE && $urandom_range(99) < 70)
            r.unit = 10'($urandom_range(CAPACITY_BYTES / BLOCK_BYTES - 1, 0));
        if (r.cmd == CMD_CERASE) r.busy = ($urandom_range(99) < 25);
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input row_t r);
        beat_t b;
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.dval, r.unit, r.len, r.addr};
        s_tuser  <= {r.busy, r.cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frame_request(r);
        case (r.chk)
            CHK_PREDICT: begin
                foreach (framed[i]) beats_due.push_back(framed[i]);
            end
            CHK_REFUSE: begin
                b = refusal(r.status);
                b.last = 1'b1;
                beats_due.push_back(b);
            end
            default: begin
                b = spi_out(r.value, 1'b1);
                b.last = 1'b1;
                beats_due.push_back(b);
            end
        endcase
        @(negedge aclk);
    endtask

    task automatic drain_requests();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (beats_due.size() != 0) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge aclk) begin
        beat_t seen;
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.spi_byte   = m_tdata[7:0];
            seen.deselect   = m_tdata[8];
            seen.read_byte  = m_tdata[16:9];
            seen.byte_valid = m_tuser[0];
            seen.read_valid = m_tuser[1];
            seen.status     = m_tuser[4:2];
            seen.last       = m_tlast;
            if (beats_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected byte %h bv %b desel %b rbyte %h rv %b st %0d lst %b",
                             $realtime, seen.spi_byte, seen.byte_valid, seen.deselect,
                             seen.read_byte, seen.read_valid, seen.status, seen.last);
            end else begin
                want = beats_due.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: exp byte %h bv %b desel %b rbyte %h rv %b st %0d lst %b",
                                 $realtime, want.spi_byte, want.byte_valid, want.deselect,
                                 want.read_byte, want.read_valid, want.status, want.last);
                        $display("%0t: got byte %h bv %b desel %b rbyte %h rv %b st %0d lst %b",
                                 $realtime, seen.spi_byte, seen.byte_valid, seen.deselect,
                                 seen.read_byte, seen.read_valid, seen.status, seen.last);
                    end
                end
            end
        end
    end

    initial begin
        row_t plan[$];
        row_t r;
        int   sent;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        //                   cmd              addr        len          unit    dval   busy
        plan.push_back(req_row(CMD_DATA,        22'h000000, 23'd0,       10'd0,    8'hA5, 1'b0,
                               CHK_REFUSE,   8'h00,     ST_NO_XFER));
        plan.push_back(req_row(CMD_UNKNOWN_MAX, 22'h3FFFFF, 23'h7FFFFF,  10'h3FF,  8'hFF, 1'b1,
                               CHK_REFUSE,   8'h00,     ST_NO_XFER));
        plan.push_back(req_row(CMD_WREN,        22'h3FFFFF, 23'h7FFFFF,  10'h3FF,  8'hFF, 1'b1,
                               CHK_ONE_BYTE, OP_WREN,   ST_OK));
        plan.push_back(req_row(CMD_WRDIS,       22'h000000, 23'd0,       10'd0,    8'h00, 1'b0,
                               CHK_ONE_BYTE, OP_WRDIS,  ST_OK));
        plan.push_back(req_row(CMD_ID,          22'h3FFFFF, 23'h7FFFFF,  10'h3FF,  8'hFF, 1'b1,
                               CHK_PREDICT,  8'h00,     ST_OK));
        plan.push_back(req_row(CMD_STATUS,      22'h000000, 23'd0,       10'd0,    8'h00, 1'b1,
                               CHK_PREDICT,  8'h00,     ST_OK));
        // zero-length read at the top byte: header only
        plan.push_back(req_row(CMD_READ,        22'h3FFFFF, 23'd0,       10'd0,    8'h00, 1'b0,
                               CHK_PREDICT,  8'h00,     ST_OK));
        plan.push_back(req_row(CMD_READ,        22'h3FFFFF, 23'd2,       10'd0,    8'h00, 1'b0,
                               CHK_REFUSE,   8'h00,     ST_RANGE));
        plan.push_back(req_row(CMD_READ,        22'h000000, 23'h7FFFFF,  10'd0,    8'h00, 1'b0,
                               CHK_REFUSE,   8'h00,     ST_RANGE));
        plan.push_back(req_row(CMD_READ,        22'h000000, 23'd1,       10'd0,    8'h00, 1'b1,
                               CHK_REFUSE,   8'h00,     ST_BUSY));
        plan.push_back(req_row(CMD_READ,        22'h3FFFFE, 23'd2,       10'd0,    8'h00, 1'b0,
                               CHK_PREDICT,  8'h00,     ST_OK));
        plan.push_back(req_row(CMD_PROG,        22'h000000, 23'd1,       10'd0,    8'h00, 1'b0,
                               CHK_REFUSE,   8'h00,     ST_OPEN));
        plan.push_back(req_row(CMD_DATA,        22'h3FFFFF, 23'h7FFFFF,  10'h3FF,  8'h00, 1'b1,
                               CHK_PREDICT,  8'h00,     ST_OK));
        plan.push_back(req_row(CMD_DATA,        22'h000000, 23'd0,       10'd0,    8'hFF, 1'b0,
                               CHK_PREDICT,  8'h00,     ST_OK));
        plan.push_back(req_row(CMD_PROG,        22'h3FFF01, 23'd1,       10'd0,    8'h00, 1'b0,
                               CHK_REFUSE,   8'h00,     ST_RANGE));
        plan.push_back(req_row(CMD_PROG,        22'h000000, 23'd0,       10'd0,    8'h00, 1'b0,
                               CHK_REFUSE,   8'h00,     ST_LENGTH));
        plan.push_back(req_row(CMD_PROG,        22'h000000, 23'd257,     10'd0,    8'h00, 1'b0,
                               CHK_REFUSE,   8'h00,     ST_LENGTH));
        // crosses into the next page
        plan.push_back(req_row(CMD_PROG,        22'h000010, 23'd241,     10'd0,    8'h00, 1'b0,
                               CHK_REFUSE,   8'h00,     ST_LENGTH));
        plan.push_back(req_row(CMD_PROG,        22'h000000, 23'd1,       10'd0,    8'h00, 1'b1,
                               CHK_REFUSE,   8'h00,     ST_BUSY));
        plan.push_back(req_row(CMD_PROG,        22'h3FFF00, 23'd1,       10'd0,    8'h00, 1'b0,
                               CHK_PREDICT,  8'h00,     ST_OK));
        plan.push_back(req_row(CMD_DATA,        22'h000000, 23'd0,       10'd0,    8'hA5, 1'b0,
                               CHK_PREDICT,  8'h00,     ST_OK));
        // sector and block erase ignore busy
        plan.push_back(req_row(CMD_SERASE,      22'h000000, 23'd0,       10'h3FF,  8'h00, 1'b1,
                               CHK_PREDICT,  8'h00,     ST_OK));
        plan.push_back(req_row(CMD_BERASE,      22'h000000, 23'd0,       10'd63,   8'h00, 1'b0,
                               CHK_PREDICT,  8'h00,     ST_OK));
        plan.push_back(req_row(CMD_BERASE,      22'h000000, 23'd0,       10'd64,   8'h00, 1'b0,
                               CHK_REFUSE,   8'h00,     ST_RANGE));
        plan.push_back(req_row(CMD_CERASE,      22'h000000, 23'd0,       10'd0,    8'h00, 1'b1,
                               CHK_REFUSE,   8'h00,     ST_BUSY));
        plan.push_back(req_row(CMD_CERASE,      22'h000000, 23'd0,       10'd0,    8'h00, 1'b0,
                               CHK_PREDICT,  8'h00,     ST_OK));

        snd_idle = 18;
        rcv_idle = 85;
        foreach (plan[i]) send_request(plan[i]);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                drain_requests();
                snd_idle = 85;
                rcv_idle = 18;
            end else if (phase == 2) begin
                drain_requests();
                snd_idle = 0;
                rcv_idle = 0;
            end
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                r = random_request();
                send_request(r);
                sent++;
            end
        end

        drain_requests();
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && beats_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
